/* design/ptbs_pkg.sv */
package ptbs_pkg;

  localparam int SIEVE_LIMIT_DEF = 131071;
  localparam int PRIME_SLOTS_DEF = 16384;

  localparam int QRY_W = 32;
  localparam int IDX_W = 14;
  localparam int VAL_W = 17;

  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic sieve_init;
    logic sieve_read;
    logic mark_init;
    logic mark_step;
    logic sieve_next;
    logic scan_init;
    logic scan_read;
    logic scan_eval;
    logic srch_init;
    logic probe_read;
    logic probe_eval;
    logic fin_read;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sq_over;
    logic is_prime;
    logic walk_over;
    logic scan_end;
    logic table_empty;
    logic srch_done;
  } dp_stat_t;

endpackage

/* design/prime_table_bound_search.sv */
// A query word is taken when start is high and busy is low; done marks the result for one cycle.
// Each query runs a probe loop of one prime memory read and one compare over the table, which holds
// 12251 primes by default; both searches share each probe.
// One query is in flight at a time; the next is taken once the last is through. done cannot be held.
// After the synchronous reset busy stays high while the table is built: a clearing pass over every
// sieve entry, the sieve, then a scan of each number up to SIEVE_LIMIT or until the slots fill.
module prime_table_bound_search
  import ptbs_pkg::*;
#(
  parameter int SIEVE_LIMIT = SIEVE_LIMIT_DEF,
  parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QRY_W-1:0] query_value,
  output logic             busy,
  output logic             done,
  output logic [IDX_W-1:0] index_at_or_above,
  output logic [VAL_W-1:0] prime_at_or_above,
  output logic [IDX_W-1:0] index_at_or_below,
  output logic [VAL_W-1:0] prime_at_or_below
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ptbs_control u_control (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ptbs_datapath #(
    .SIEVE_LIMIT (SIEVE_LIMIT),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_datapath (
    .clk               (clk),
    .cmd               (cmd),
    .query_value       (query_value),
    .stat              (stat),
    .index_at_or_above (index_at_or_above),
    .prime_at_or_above (prime_at_or_above),
    .index_at_or_below (index_at_or_below),
    .prime_at_or_below (prime_at_or_below)
  );

endmodule

/* design/ptbs_datapath.sv */
module ptbs_datapath
  import ptbs_pkg::*;
#(
  parameter int SIEVE_LIMIT = SIEVE_LIMIT_DEF,
  parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
) (
  input  logic             clk,
  input  dp_cmd_t          cmd,
  input  logic [QRY_W-1:0] query_value,
  output dp_stat_t         stat,
  output logic [IDX_W-1:0] index_at_or_above,
  output logic [VAL_W-1:0] prime_at_or_above,
  output logic [IDX_W-1:0] index_at_or_below,
  output logic [VAL_W-1:0] prime_at_or_below
);

  localparam int AW = $clog2(SIEVE_LIMIT + 1);
  localparam int VW = AW + 1;
  localparam int PW = $clog2(PRIME_SLOTS);
  localparam int TW = PW + 1;
  localparam logic [VW-1:0] LIMIT = VW'(SIEVE_LIMIT);
  localparam logic [TW-1:0] SLOTS = TW'(PRIME_SLOTS);

  logic          comp_mem  [0:SIEVE_LIMIT];
  logic [AW-1:0] prime_mem [0:PRIME_SLOTS-1];

  logic [VW-1:0]    walk;
  logic [VW-1:0]    base;
  logic [VW-1:0]    sq;
  logic             comp_rd;
  logic [TW-1:0]    total;
  logic [QRY_W-1:0] query;
  logic [PW-1:0]    lo_a;
  logic [PW-1:0]    hi_a;
  logic [PW-1:0]    lo_b;
  logic [PW-1:0]    hi_b;
  logic [PW-1:0]    mid_a;
  logic [PW-1:0]    mid_b;
  logic [PW-1:0]    addr_a;
  logic [PW-1:0]    addr_b;
  logic [PW:0]      span_b;
  logic [AW-1:0]    rd_a;
  logic [AW-1:0]    rd_b;

  // Sieve memory: cleared, then marked, then scanned.
  always_ff @(posedge clk) begin
    if (cmd.clr_step || cmd.mark_step) begin
      comp_mem[walk[AW-1:0]] <= cmd.mark_step;
    end
    if (cmd.sieve_read || cmd.scan_read) begin
      comp_rd <= comp_mem[base[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_init) begin
      walk <= '0;
    end else if (cmd.clr_step) begin
      walk <= walk + VW'(1);
    end else if (cmd.mark_init) begin
      walk <= sq;
    end else if (cmd.mark_step) begin
      walk <= walk + base;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sieve_init) begin
      base <= VW'(2);
      sq   <= VW'(4);
    end else if (cmd.sieve_next) begin
      base <= base + VW'(1);
      sq   <= sq + {base[VW-2:0], 1'b1};
    end else if (cmd.scan_init) begin
      base <= VW'(2);
    end else if (cmd.scan_eval) begin
      base <= base + VW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      total <= '0;
    end else if (cmd.scan_eval && !comp_rd) begin
      prime_mem[total[PW-1:0]] <= base[AW-1:0];
      total <= total + TW'(1);
    end
  end

  assign mid_a  = lo_a + ((hi_a - lo_a) >> 1);
  assign span_b = {1'b0, hi_b} - {1'b0, lo_b} + (PW+1)'(1);
  assign mid_b  = lo_b + span_b[PW:1];
  assign addr_a = cmd.fin_read ? lo_a : mid_a;
  assign addr_b = cmd.fin_read ? lo_b : mid_b;

  always_ff @(posedge clk) begin
    if (cmd.probe_read || cmd.fin_read) begin
      rd_a <= prime_mem[addr_a];
      rd_b <= prime_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      query <= query_value;
      lo_a  <= '0;
      hi_a  <= PW'(total - TW'(1));
      lo_b  <= '0;
      hi_b  <= PW'(total - TW'(1));
    end else if (cmd.probe_eval) begin
      if (lo_a < hi_a) begin
        if (QRY_W'(rd_a) < query) begin
          lo_a <= mid_a + PW'(1);
        end else begin
          hi_a <= mid_a;
        end
      end
      if (lo_b < hi_b) begin
        if (QRY_W'(rd_b) > query) begin
          hi_b <= mid_b - PW'(1);
        end else begin
          lo_b <= mid_b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (stat.table_empty) begin
        index_at_or_above <= '0;
        prime_at_or_above <= '0;
        index_at_or_below <= '0;
        prime_at_or_below <= '0;
      end else begin
        index_at_or_above <= IDX_W'(lo_a);
        prime_at_or_above <= VAL_W'(rd_a);
        index_at_or_below <= IDX_W'(lo_b);
        prime_at_or_below <= VAL_W'(rd_b);
      end
    end
  end

  assign stat.clr_last    = (walk == LIMIT);
  assign stat.sq_over     = (sq > LIMIT);
  assign stat.is_prime    = !comp_rd;
  assign stat.walk_over   = (walk > LIMIT);
  assign stat.scan_end    = (base > LIMIT) || (total == SLOTS);
  assign stat.table_empty = (total == '0);
  assign stat.srch_done   = !(lo_a < hi_a) && !(lo_b < hi_b);

endmodule

/* design/ptbs_control.sv */
module ptbs_control
  import ptbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  localparam logic [3:0] S_BOOT    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_SV_CHK  = 4'd2;
  localparam logic [3:0] S_SV_WAIT = 4'd3;
  localparam logic [3:0] S_MARK    = 4'd4;
  localparam logic [3:0] S_SC_RD   = 4'd5;
  localparam logic [3:0] S_SC_EV   = 4'd6;
  localparam logic [3:0] S_IDLE    = 4'd7;
  localparam logic [3:0] S_PR_RD   = 4'd8;
  localparam logic [3:0] S_PR_EV   = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_BOOT: begin
        cmd.clr_init = 1'b1;
        state_next   = S_CLR;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.sieve_init = 1'b1;
          state_next     = S_SV_CHK;
        end
      end
      S_SV_CHK: begin
        if (stat.sq_over) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SC_RD;
        end else begin
          cmd.sieve_read = 1'b1;
          state_next     = S_SV_WAIT;
        end
      end
      S_SV_WAIT: begin
        if (stat.is_prime) begin
          cmd.mark_init = 1'b1;
          state_next    = S_MARK;
        end else begin
          cmd.sieve_next = 1'b1;
          state_next     = S_SV_CHK;
        end
      end
      S_MARK: begin
        if (stat.walk_over) begin
          cmd.sieve_next = 1'b1;
          state_next     = S_SV_CHK;
        end else begin
          cmd.mark_step = 1'b1;
        end
      end
      S_SC_RD: begin
        if (stat.scan_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.scan_read = 1'b1;
          state_next    = S_SC_EV;
        end
      end
      S_SC_EV: begin
        cmd.scan_eval = 1'b1;
        state_next    = S_SC_RD;
      end
      S_IDLE: begin
        if (start) begin
          cmd.srch_init = 1'b1;
          state_next    = S_PR_RD;
        end
      end
      S_PR_RD: begin
        if (stat.srch_done || stat.table_empty) begin
          cmd.fin_read = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.probe_read = 1'b1;
          state_next     = S_PR_EV;
        end
      end
      S_PR_EV: begin
        cmd.probe_eval = 1'b1;
        state_next     = S_PR_RD;
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_BOOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.out_load;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

/* design/ptbs_checker.sv */
module ptbs_checker
  import ptbs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [IDX_W-1:0] index_at_or_above,
  input logic [VAL_W-1:0] prime_at_or_above,
  input logic [IDX_W-1:0] index_at_or_below,
  input logic [VAL_W-1:0] prime_at_or_below
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted query");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a query in progress");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    done |-> (prime_at_or_below <= prime_at_or_above) &&
             (index_at_or_below <= index_at_or_above))
    else $error("lower bound lies above upper bound");

endmodule

bind prime_table_bound_search ptbs_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .done              (done),
  .index_at_or_above (index_at_or_above),
  .prime_at_or_above (prime_at_or_above),
  .index_at_or_below (index_at_or_below),
  .prime_at_or_below (prime_at_or_below)
);

/* tb/sv/prime_table_bound_search_tb.sv */
module prime_table_bound_search_tb;
  import ptbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIEVE_MAX   = SIEVE_LIMIT_DEF;
  localparam int SLOT_COUNT  = PRIME_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [QRY_W-1:0] query;
    logic [IDX_W-1:0] idx_up;
    logic [VAL_W-1:0] val_up;
    logic [IDX_W-1:0] idx_dn;
    logic [VAL_W-1:0] val_dn;
  } bounds_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic [QRY_W-1:0] query_value;
  logic             busy;
  logic             done;
  logic [IDX_W-1:0] index_at_or_above;
  logic [VAL_W-1:0] prime_at_or_above;
  logic [IDX_W-1:0] index_at_or_below;
  logic [VAL_W-1:0] prime_at_or_below;

  bit      sieve_marks [0:SIEVE_MAX];
  int      prime_table [0:SLOT_COUNT-1];
  int      stored_primes;
  bounds_t pending_bounds [$];
  int      mismatch_count;
  int      sender_gap_pct;
  int      cycle_count;

  prime_table_bound_search #(
    .SIEVE_LIMIT(SIEVE_MAX),
    .PRIME_SLOTS(SLOT_COUNT)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .query_value      (query_value),
    .busy             (busy),
    .done             (done),
    .index_at_or_above(index_at_or_above),
    .prime_at_or_above(prime_at_or_above),
    .index_at_or_below(index_at_or_below),
    .prime_at_or_below(prime_at_or_below)
  );

  initial clk = 1'b0;
  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void build_prime_table();
    int i;
    int j;
    for (i = 0; i <= SIEVE_MAX; i++) sieve_marks[i] = 1'b0;
    for (i = 0; i < SLOT_COUNT; i++) prime_table[i] = 0;
    stored_primes = 0;
    sieve_marks[0] = 1'b1;
    sieve_marks[1] = 1'b1;
    for (i = 2; longint'(i) * i <= SIEVE_MAX; i++) begin
      if (!sieve_marks[i]) begin
        for (j = i * i; j <= SIEVE_MAX; j += i) sieve_marks[j] = 1'b1;
      end
    end
    for (i = 2; i <= SIEVE_MAX; i++) begin
      if (!sieve_marks[i]) begin
        if (stored_primes >= SLOT_COUNT) break;
        prime_table[stored_primes] = i;
        stored_primes++;
      end
    end
  endfunction

  function automatic bounds_t predict_bounds(input logic [QRY_W-1:0] q);
    bounds_t b;
    int lo;
    int hi;
    int mid;
    int up;
    int dn;
    b = '0;
    b.query = q;
    if (stored_primes == 0) return b;
    lo = 0;
    hi = stored_primes - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (longint'(prime_table[mid]) < longint'(q)) lo = mid + 1;
      else hi = mid;
    end
    up = lo;
    lo = 0;
    hi = stored_primes - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (longint'(prime_table[mid]) > longint'(q)) hi = mid - 1;
      else lo = mid;
    end
    dn = lo;
    b.idx_up = up[IDX_W-1:0];
    b.val_up = prime_table[up][VAL_W-1:0];
    b.idx_dn = dn[IDX_W-1:0];
    b.val_dn = prime_table[dn][VAL_W-1:0];
    return b;
  endfunction

  always @(posedge clk) begin
    bounds_t exp_b;
    if (!rst && done) begin
      if (pending_bounds.size() == 0) begin
        $display("%0t: result with no query waiting: %0d %0d %0d %0d", $time,
                 index_at_or_above, prime_at_or_above, index_at_or_below, prime_at_or_below);
        mismatch_count++;
      end else begin
        exp_b = pending_bounds.pop_front();
        if (index_at_or_above !== exp_b.idx_up) begin
          $display("%0t: query %0d index_at_or_above expected %0d, got %0d", $time,
                   exp_b.query, exp_b.idx_up, index_at_or_above);
          mismatch_count++;
        end
        if (prime_at_or_above !== exp_b.val_up) begin
          $display("%0t: query %0d prime_at_or_above expected %0d, got %0d", $time,
                   exp_b.query, exp_b.val_up, prime_at_or_above);
          mismatch_count++;
        end
        if (index_at_or_below !== exp_b.idx_dn) begin
          $display("%0t: query %0d index_at_or_below expected %0d, got %0d", $time,
                   exp_b.query, exp_b.idx_dn, index_at_or_below);
          mismatch_count++;
        end
        if (prime_at_or_below !== exp_b.val_dn) begin
          $display("%0t: query %0d prime_at_or_below expected %0d, got %0d", $time,
                   exp_b.query, exp_b.val_dn, prime_at_or_below);
          mismatch_count++;
        end
      end
    end
  end

  // Start stays high from one word to the next unless a gap is chosen, so it is never
  // lowered and raised within the same falling edge.
  task automatic send_query(input logic [QRY_W-1:0] q);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_gap_pct) gap = $urandom_range(1, 45);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    query_value <= q;
    do @(posedge clk); while (busy);
    pending_bounds.insert(pending_bounds.size(), predict_bounds(q));
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
  endtask

  function automatic logic [QRY_W-1:0] pick_query();
    int sel;
    int offset;
    sel = $urandom_range(99);
    if (sel < 45) return QRY_W'($urandom_range(0, SIEVE_MAX + 64));
    if (sel < 75) begin
      offset = int'($urandom_range(0, 2)) - 1;
      return QRY_W'(prime_table[$urandom_range(0, stored_primes - 1)] + offset);
    end
    if (sel < 85) return QRY_W'($urandom_range(0, 40));
    return $urandom();
  endfunction

  task automatic test_field_extremes();
    send_query(32'h0000_0000);
    send_query(32'hFFFF_FFFF);
    send_query(32'h8000_0000);
    send_query(32'h7FFF_FFFF);
    send_query(32'h5555_5555);
    send_query(32'hAAAA_AAAA);
  endtask

  task automatic test_table_bounds();
    send_query(32'd1);
    send_query(32'd2);
    send_query(32'd3);
    send_query(QRY_W'(prime_table[stored_primes - 1] - 1));
    send_query(QRY_W'(prime_table[stored_primes - 1]));
    send_query(QRY_W'(prime_table[stored_primes - 1] + 1));
    send_query(QRY_W'(SIEVE_MAX));
    send_query(QRY_W'(SIEVE_MAX + 1));
  endtask

  task automatic test_prime_gaps();
    send_query(32'd24);
    send_query(32'd25);
    send_query(32'd114);
    send_query(32'd121);
    send_query(32'd65536);
    send_query(32'd99991);
    send_query(32'd100000);
    send_query(32'd100003);
    send_query(QRY_W'(prime_table[stored_primes / 2]));
  endtask

  task automatic test_random_queries(input int count);
    repeat (count) send_query(pick_query());
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    query_value    = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    sender_gap_pct = 26;
    build_prime_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_table_bounds();
    test_prime_gaps();
    test_random_queries(330);
    drain_results();
    sender_gap_pct = 80;
    test_random_queries(330);
    drain_results();
    sender_gap_pct = 0;
    test_random_queries(320);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_bounds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ptbs_pkg.sv
design/ptbs_datapath.sv
design/ptbs_control.sv
design/prime_table_bound_search.sv
design/ptbs_checker.sv
tb/sv/prime_table_bound_search_tb.sv
